>>> src/lzss_pkg.sv
// Shared types, constants and ring index helpers for the LZSS decompressor.
package lzss_pkg;

  localparam int RING_SIZE  = 4096;
  localparam int RING_AW    = $clog2(RING_SIZE);
  localparam int MAX_COPY   = 18;
  localparam int LEN_BIAS   = 2;
  localparam int POS_MAX    = 4095;
  localparam int MOD_STEPS  = $clog2(POS_MAX / RING_SIZE + 1);

  localparam logic [7:0]         SPACE_BYTE = 8'h20;
  localparam logic [RING_AW-1:0] WP_INIT    = RING_AW'(RING_SIZE - MAX_COPY);
  localparam logic [RING_AW-1:0] RING_LAST  = RING_AW'(RING_SIZE - 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR
  } dec_state_t;

  // 12-bit position reduced into the ring; with MOD_STEPS zero no step runs
  function automatic logic [RING_AW-1:0] ring_mod(input logic [11:0] p);
    logic [12:0] v;
    v = {1'b0, p};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (v >= 13'(RING_SIZE << k)) begin
        v = v - 13'(RING_SIZE << k);
      end
    end
    return v[RING_AW-1:0];
  endfunction

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] a);
    return (a == RING_LAST) ? '0 : a + 1'b1;
  endfunction

endpackage

>>> src/lzss_ring_ram.sv
// Ring window memory: one write port, one registered read port, write-first.
module lzss_ring_ram
  import lzss_pkg::*;
(
  input  logic      clk,
  input  ring_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [RING_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // same-cycle write to the read address is forwarded (overlapping copies)
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= (req.we && req.waddr == req.raddr) ? req.wdata : mem[req.raddr];
    end
  end

endmodule

>>> src/lzss_decoder.sv
// Token decoder: flag tracking, reference copy sequencer, ring clear and output register.
module lzss_decoder
  import lzss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  output ring_req_t  ring_req,
  input  logic [7:0] ring_rdata
);

  dec_state_t         state, state_next;
  logic [15:0]        flag_shift, flag_shift_next;
  logic [RING_AW-1:0] wp, wp_next;
  logic [RING_AW-1:0] src, src_next;
  logic [RING_AW-1:0] clr_addr, clr_addr_next;
  logic [7:0]         pending_low, pending_low_next;
  logic               awaiting_high, awaiting_high_next;
  logic [4:0]         remaining, remaining_next;
  logic               eos_pend, eos_pend_next;
  logic               out_valid_next;
  out_item_t          out_item_next;
  logic               out_free;
  logic               accept;
  logic [7:0]         b;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == ST_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      flag_shift    <= '0;
      awaiting_high <= 1'b0;
      eos_pend      <= 1'b0;
      out_valid     <= 1'b0;
      wp            <= WP_INIT;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      flag_shift    <= flag_shift_next;
      awaiting_high <= awaiting_high_next;
      eos_pend      <= eos_pend_next;
      out_valid     <= out_valid_next;
      wp            <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    src         <= src_next;
    pending_low <= pending_low_next;
    remaining   <= remaining_next;
    out_item    <= out_item_next;
  end

  always_comb begin
    state_next         = state;
    flag_shift_next    = flag_shift;
    wp_next            = wp;
    src_next           = src;
    clr_addr_next      = clr_addr;
    pending_low_next   = pending_low;
    awaiting_high_next = awaiting_high;
    remaining_next     = remaining;
    eos_pend_next      = eos_pend;
    out_valid_next     = out_valid && out_stall;
    out_item_next      = out_item;
    ring_req           = '0;

    unique case (state)
      ST_CLEAR: begin
        ring_req.we        = 1'b1;
        ring_req.waddr     = clr_addr;
        ring_req.wdata     = SPACE_BYTE;
        flag_shift_next    = '0;
        pending_low_next   = '0;
        awaiting_high_next = 1'b0;
        eos_pend_next      = 1'b0;
        if (clr_addr == RING_LAST) begin
          clr_addr_next = '0;
          wp_next       = WP_INIT;
          state_next    = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (awaiting_high) begin
            src_next           = ring_mod({b[7:4], pending_low});
            remaining_next     = 5'(b[3:0]) + 5'(LEN_BIAS + 1);
            awaiting_high_next = 1'b0;
            flag_shift_next    = flag_shift >> 1;
            eos_pend_next      = in_item.end_of_stream;
            state_next         = ST_COPY_RD;
          end else begin
            if (!flag_shift[8]) begin
              flag_shift_next = {8'hFF, b};
            end else if (flag_shift[0]) begin
              out_valid_next         = 1'b1;
              out_item_next.out_byte = b;
              out_item_next.out_last = 1'b1;
              ring_req.we            = 1'b1;
              ring_req.waddr         = wp;
              ring_req.wdata         = b;
              wp_next                = ring_inc(wp);
              flag_shift_next        = flag_shift >> 1;
            end else begin
              pending_low_next   = b;
              awaiting_high_next = 1'b1;
            end
            if (in_item.end_of_stream) begin
              state_next = ST_CLEAR;
            end
          end
        end
      end
      ST_COPY_RD: begin
        ring_req.re    = 1'b1;
        ring_req.raddr = src;
        src_next       = ring_inc(src);
        state_next     = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        // read data stays put while the output is blocked
        if (out_free) begin
          out_valid_next         = 1'b1;
          out_item_next.out_byte = ring_rdata;
          out_item_next.out_last = (remaining == 5'd1);
          ring_req.we            = 1'b1;
          ring_req.waddr         = wp;
          ring_req.wdata         = ring_rdata;
          wp_next                = ring_inc(wp);
          remaining_next         = remaining - 1'b1;
          if (remaining == 5'd1) begin
            state_next = eos_pend ? ST_CLEAR : ST_IDLE;
          end else begin
            ring_req.re    = 1'b1;
            ring_req.raddr = src;
            src_next       = ring_inc(src);
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> src/lzss_decompressor.sv
// Top level of the LZSS decompressor: decoder plus ring window memory.
// One compressed byte per input transaction. Flag bytes, literals and the low
// byte of a reference are taken while the decoder is idle and its output
// register is free. The high byte of a reference starts a copy of 3 to 18 bytes,
// one byte per cycle through the single read port of the ring memory while
// the output is not stalled. After reset, and after an item marked
// end_of_stream, the ring is refilled with spaces one entry a cycle, and no
// input is taken until it is full.
module lzss_decompressor
  import lzss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ring_req_t  ring_req;
  logic [7:0] ring_rdata;

  lzss_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata)
  );

  lzss_ring_ram u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LZSS decompressor: directed tokens, then random streams.
module testbench
  import lzss_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 2 * MAX_COPY;
  localparam int RANDOM_ITEMS   = 230;

  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  lzss_decompressor u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // Decoder shadow state
  logic [7:0]  win_mem [RING_SIZE];
  logic [15:0] flag_bits;
  int          wr_ptr;
  logic [7:0]  ref_low;
  logic        want_high;
  out_item_t   exp_bytes [$];

  in_item_t    send_q [$];
  idle_phase_t phase = PH_FREE;
  int          gap_pct [4] = '{0, 86, 0, 32};
  int          stall_pct [4] = '{0, 0, 86, 32};
  logic        hold_send = 1'b0;
  logic        acc_fire = 1'b0;
  in_item_t    acc_item = '0;
  int          n_sent = 0;
  int          n_err = 0;
  int          idle_cycles = 0;
  out_item_t   want;

  function automatic in_item_t mk(input logic [7:0] b, input logic eos);
    in_item_t it;
    it.in_byte = b;
    it.end_of_stream = eos;
    return it;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < RING_SIZE; i++) win_mem[i] = SPACE_BYTE;
    flag_bits = '0;
    wr_ptr = WP_INIT;
    ref_low = '0;
    want_high = 1'b0;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    out_item_t o;
    o.out_byte = b;
    o.out_last = 1'b0;
    exp_bytes.push_back(o);
    win_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % RING_SIZE;
  endfunction

  // Expected output bytes for one compressed byte
  function automatic void decode_byte(input in_item_t it);
    int pos;
    int len;
    int n0;
    out_item_t o;
    n0 = exp_bytes.size();
    if (want_high) begin
      pos = {it.in_byte[7:4], ref_low};
      len = it.in_byte[3:0] + LEN_BIAS;
      // overlapping copies read bytes written earlier in this same loop
      for (int k = 0; k <= len; k++) emit_byte(win_mem[(pos + k) % RING_SIZE]);
      want_high = 1'b0;
      flag_bits = flag_bits >> 1;
    end else if (!flag_bits[8]) begin
      flag_bits = {8'hFF, it.in_byte};
    end else if (flag_bits[0]) begin
      emit_byte(it.in_byte);
      flag_bits = flag_bits >> 1;
    end else begin
      ref_low = it.in_byte;
      want_high = 1'b1;
    end
    if (exp_bytes.size() > n0) begin
      o = exp_bytes.pop_back();
      o.out_last = 1'b1;
      exp_bytes.push_back(o);
    end
    if (it.end_of_stream) clear_window();
  endfunction

  // One compressed stream; references point just behind the write pointer half the time
  task automatic gen_stream();
    in_item_t s [$];
    in_item_t it;
    logic [7:0] fl;
    int gw;
    int pos;
    int len;
    int cut;
    gw = WP_INIT;
    if ($urandom_range(0, 9) >= 7) begin
      repeat ($urandom_range(3, 15)) s.push_back(mk(8'($urandom), 1'b0));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        fl = 8'($urandom);
        s.push_back(mk(fl, 1'b0));
        for (int t = 0; t < 8; t++) begin
          if (fl[t]) begin
            s.push_back(mk(8'($urandom), 1'b0));
            gw = (gw + 1) % RING_SIZE;
          end else begin
            len = $urandom_range(0, 15);
            if ($urandom_range(0, 3) < 2) begin
              pos = (gw + RING_SIZE - $urandom_range(1, 20)) % RING_SIZE;
            end else begin
              pos = $urandom_range(0, RING_SIZE - 1);
            end
            s.push_back(mk(pos[7:0], 1'b0));
            s.push_back(mk({pos[11:8], len[3:0]}, 1'b0));
            gw = (gw + len + 3) % RING_SIZE;
          end
        end
      end
      // broken stream: cut anywhere, possibly mid-token
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, s.size());
        while (s.size() > cut) void'(s.pop_back());
      end
    end
    it = s.pop_back();
    it.end_of_stream = 1'b1;
    s.push_back(it);
    foreach (s[i]) send_q.push_back(s[i]);
  endtask

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      acc_fire <= 1'b0;
    end else begin
      acc_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        acc_item <= in_item;
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_q.size() > 0 && !hold_send && $urandom_range(0, 99) >= gap_pct[phase]) begin
          in_item <= send_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict last cycle's transaction first, then check this cycle's output
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (acc_fire) decode_byte(acc_item);
      if (out_valid && !out_stall) begin
        if (exp_bytes.size() == 0) begin
          flag_error($sformatf("unexpected output byte %02h last %0b",
                               out_item.out_byte, out_item.out_last));
        end else begin
          want = exp_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte || out_item.out_last !== want.out_last)
            flag_error($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                 want.out_byte, out_item.out_byte,
                                 want.out_last, out_item.out_last));
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct[phase]);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int total;
    clear_window();

    // literal, overlapping wrap-around copy, extreme positions and lengths
    send_q.push_back(mk(8'hE5, 1'b0));
    send_q.push_back(mk(8'h00, 1'b0));
    send_q.push_back(mk(8'hEE, 1'b0));
    send_q.push_back(mk(8'hFF, 1'b0));
    send_q.push_back(mk(8'hFF, 1'b0));
    send_q.push_back(mk(8'h00, 1'b0));
    send_q.push_back(mk(8'h00, 1'b0));
    send_q.push_back(mk(8'hFF, 1'b0));
    send_q.push_back(mk(8'hFF, 1'b0));
    send_q.push_back(mk(8'hA5, 1'b0));
    send_q.push_back(mk(8'h5A, 1'b0));
    send_q.push_back(mk(8'h80, 1'b0));
    // end of stream after the low byte of a reference
    send_q.push_back(mk(8'h00, 1'b0));
    send_q.push_back(mk(8'h12, 1'b1));
    // end of stream on a flag byte, then a copy from the fresh window
    send_q.push_back(mk(8'h00, 1'b1));
    send_q.push_back(mk(8'hFE, 1'b0));
    send_q.push_back(mk(8'h10, 1'b0));
    send_q.push_back(mk(8'h7F, 1'b0));
    send_q.push_back(mk(8'h7E, 1'b1));

    total = send_q.size();
    while (send_q.size() < total + RANDOM_ITEMS) gen_stream();
    total = send_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (n_sent < total / 4) @(negedge clk);
    phase = PH_SEND_IDLE;
    while (n_sent < total / 2) @(negedge clk);
    hold_send = 1'b1;
    while (in_valid || acc_fire || exp_bytes.size() > 0) @(negedge clk);
    hold_send = 1'b0;
    phase = PH_RECV_STALL;
    while (n_sent < 3 * total / 4) @(negedge clk);
    phase = PH_BOTH;
    while (send_q.size() > 0 || in_valid || acc_fire || exp_bytes.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (exp_bytes.size() > 0) $display("%0d expected bytes never arrived", exp_bytes.size());
    if (n_err == 0 && exp_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
